// ===== design/rpp_pkg.sv =====
// RTCP report parser package: result record type, push bundle, phase enum,
// protocol constants. No dependencies.
`default_nettype none

package rpp_pkg;

    localparam logic [7:0] PREFIX_MARK = 8'h24;  // '$' interleave marker
    localparam logic [4:0] PREFIX_LEN  = 5'd4;
    localparam logic [4:0] HEADER_LEN  = 5'd4;
    localparam logic [4:0] SSRC_LEN    = 5'd4;
    localparam logic [4:0] RECORD_LEN  = 5'd24;

    localparam logic [7:0] PT_SR   = 8'd200;
    localparam logic [7:0] PT_RR   = 8'd201;
    localparam logic [7:0] PT_SDES = 8'd202;
    localparam logic [7:0] PT_APP  = 8'd204;

    localparam logic [1:0] KIND_SENDER = 2'd0;
    localparam logic [1:0] KIND_BLOCK  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_PREFIX = 4'd1,
        PH_HEADER = 4'd2,
        PH_SENDER = 4'd3,
        PH_RRSSRC = 4'd4,
        PH_BLOCK  = 4'd5,
        PH_DRAIN  = 4'd6
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [7:0]  payload_type;
        logic [31:0] ssrc;
        logic [63:0] ntp_timestamp;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
        logic [7:0]  fraction_lost;
        logic [23:0] cumulative_lost;
        logic        end_of_run;
    } result_t;

    // Results produced by one byte: count (0..2), first and second in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// ===== design/rpp_in_if.sv =====
// Packet byte channel: valid/ready with byte and end marker.
// No dependencies.
`default_nettype none

interface rpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_packet;

    modport source (output valid, output byte_in, output end_of_packet, input ready);
    modport sink   (input valid, input byte_in, input end_of_packet, output ready);
endinterface

`default_nettype wire

// ===== design/rpp_out_if.sv =====
// Result record channel: valid/ready with one result_t per beat.
// Depends on rpp_pkg.
`default_nettype none

interface rpp_out_if
    import rpp_pkg::*;
    ;
    logic    valid;
    logic    ready;
    result_t result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== design/rtcp_report_parser.sv =====
// RTCP SR/RR report parser top: byte parser feeding a result queue.
// Depends on rpp_pkg, rpp_in_if, rpp_out_if, rpp_parse, rpp_result_fifo.
//
//  port    | role | beat contents
//  --------+------+-----------------------------------------------------
//  packet  | sink | byte_in, end_of_packet (one packet byte per beat)
//  report  | src  | result: sender info, report block or packet status
//
// One byte per cycle while packet.ready is high; each byte is parsed in the cycle it is
// taken and its 0..2 results land in a four-entry queue the same edge.
// Results leave one per cycle while report.ready is high; the record and
// status caused by one byte leave as two separate beats on the report side.
// packet.ready drops only while the queue holds three or more results,
// i.e. when the report side stalls.
// Reset clears parser phase, counters and queue pointers; no clearing pass.
`default_nettype none

module rtcp_report_parser
    import rpp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rpp_in_if.sink    packet,
    rpp_out_if.source report
);

    push_t      push;
    logic [2:0] level;
    logic       room;

    // room for a worst-case byte (record plus status)
    assign room = (level <= 3'd2);

    rpp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (packet),
        .room   (room),
        .push   (push)
    );

    rpp_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .report (report),
        .level  (level)
    );

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n) level <= 3'd4)
        else $error("result queue overflow");

    // a double push is always record then closing status
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (push.second.kind == KIND_STATUS &&
                                push.second.end_of_run && !push.first.end_of_run))
        else $error("bad result pair order");

    // an empty queue with no push shows nothing next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (level == 3'd0 && push.count == 2'd0) |=> !report.valid)
        else $error("phantom result");

endmodule

`default_nettype wire

// ===== design/rpp_parse.sv =====
// Byte-level parser state and record assembly; emits up to two results per
// accepted byte. Depends on rpp_pkg, rpp_in_if.
`default_nettype none

module rpp_parse
    import rpp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rpp_in_if.sink    packet,
    input  wire logic room,
    output push_t     push
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  count_reg, count_next;
    logic        skip_reg, skip_next;
    logic [31:0] header_reg, header_next;
    logic [4:0]  blocks_reg, blocks_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] ssrc_reg, ssrc_next;
    logic [63:0] ntp_reg, ntp_next;
    logic [31:0] word_reg [4];
    logic [31:0] word_next [4];
    logic [31:0] loss_reg, loss_next;
    logic [1:0]  err_reg, err_next;

    logic fire;
    assign packet.ready = room;
    assign fire = packet.valid & room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            skip_reg   <= 1'b0;
            header_reg <= '0;
            blocks_reg <= '0;
            shift_reg  <= '0;
            ssrc_reg   <= '0;
            ntp_reg    <= '0;
            word_reg   <= '{default: '0};
            loss_reg   <= '0;
            err_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            skip_reg   <= skip_next;
            header_reg <= header_next;
            blocks_reg <= blocks_next;
            shift_reg  <= shift_next;
            ssrc_reg   <= ssrc_next;
            ntp_reg    <= ntp_next;
            word_reg   <= word_next;
            loss_reg   <= loss_next;
            err_reg    <= err_next;
        end
    end

    always_comb
    begin
        logic [7:0]  b;
        logic [2:0]  slot;
        logic        sender;
        logic        rec_valid;
        logic        hdr;
        logic [1:0]  st;
        logic [4:0]  rc;
        logic [7:0]  pt;
        result_t     rec;
        result_t     stat;

        b          = packet.byte_in;
        phase_next  = phase_reg;
        count_next  = count_reg;
        skip_next   = skip_reg;
        header_next = header_reg;
        blocks_next = blocks_reg;
        shift_next  = shift_reg;
        ssrc_next   = ssrc_reg;
        ntp_next    = ntp_reg;
        word_next   = word_reg;
        loss_next   = loss_reg;
        err_next    = err_reg;
        rec_valid   = 1'b0;
        rec         = '0;
        stat        = '0;
        slot        = '0;
        sender      = (phase_reg == PH_SENDER);
        rc          = header_reg[28:24];
        pt          = header_reg[23:16];

        case (phase_reg)
            PH_PREFIX:
            begin
                count_next = count_reg + 5'd1;
                if (count_next >= PREFIX_LEN)
                begin
                    phase_next  = PH_HEADER;
                    count_next  = '0;
                    header_next = '0;
                end
            end
            PH_HEADER:
            begin
                header_next = {header_reg[23:0], b};
                count_next  = count_reg + 5'd1;
                if (count_next >= HEADER_LEN)
                begin
                    rc          = header_next[28:24];
                    pt          = header_next[23:16];
                    err_next    = ST_OK;
                    blocks_next = rc;
                    count_next  = '0;
                    if (rc == 5'd0)
                        phase_next = PH_DRAIN;
                    else if (pt == PT_SR)
                        phase_next = PH_SENDER;
                    else if (pt == PT_RR)
                        phase_next = PH_RRSSRC;
                    else if (pt >= PT_SDES && pt <= PT_APP)
                        phase_next = PH_DRAIN;
                    else
                    begin
                        phase_next = PH_DRAIN;
                        err_next   = ST_UNKNOWN;
                    end
                end
            end
            PH_SENDER, PH_RRSSRC, PH_BLOCK:
            begin
                shift_next = {shift_reg[23:0], b};
                count_next = count_reg + 5'd1;
                if (count_next[1:0] == 2'd0)
                begin
                    // word slot within the record, one per four bytes
                    slot = count_next[4:2] - 3'd1;
                    case (slot)
                        3'd0: ssrc_next = shift_next;
                        3'd1:
                        begin
                            if (sender)
                                ntp_next = {shift_next, 32'd0};
                            else
                                loss_next = shift_next;
                        end
                        3'd2:
                        begin
                            word_next[0] = shift_next;
                            if (sender)
                                ntp_next = {ntp_reg[63:32], shift_next};
                        end
                        3'd3: word_next[1] = shift_next;
                        3'd4: word_next[2] = shift_next;
                        3'd5: word_next[3] = shift_next;
                        default: ;
                    endcase
                end
                if (phase_reg == PH_RRSSRC && count_next >= SSRC_LEN)
                begin
                    phase_next = PH_BLOCK;
                    count_next = '0;
                end
                else if (phase_reg != PH_RRSSRC && count_next >= RECORD_LEN)
                begin
                    rec_valid        = 1'b1;
                    rec.payload_type = header_reg[23:16];
                    rec.ssrc         = ssrc_next;
                    if (sender)
                    begin
                        rec.kind          = KIND_SENDER;
                        rec.ntp_timestamp = ntp_next;
                        rec.word_a        = word_next[1];
                        rec.word_b        = word_next[2];
                        rec.word_c        = word_next[3];
                        phase_next        = PH_BLOCK;
                    end
                    else
                    begin
                        rec.kind            = KIND_BLOCK;
                        rec.word_a          = word_next[0];
                        rec.word_b          = word_next[1];
                        rec.word_c          = word_next[2];
                        rec.word_d          = word_next[3];
                        rec.fraction_lost   = loss_next[31:24];
                        rec.cumulative_lost = loss_next[23:0];
                        blocks_next         = blocks_reg - 5'd1;
                        if (blocks_next == 5'd0)
                        begin
                            phase_next = PH_DRAIN;
                            err_next   = ST_OK;
                        end
                    end
                    count_next = '0;
                end
            end
            PH_DRAIN: ;
            default:
            begin
                // idle, and any unused phase code
                count_next = 5'd1;
                if (b == PREFIX_MARK)
                begin
                    skip_next   = 1'b1;
                    phase_next  = PH_PREFIX;
                    header_next = '0;
                end
                else
                begin
                    skip_next   = 1'b0;
                    header_next = {24'd0, b};
                    phase_next  = PH_HEADER;
                end
            end
        endcase

        // end-of-packet status, judged on the phase after this byte
        hdr = (phase_next == PH_SENDER) || (phase_next == PH_RRSSRC) ||
              (phase_next == PH_BLOCK) || (phase_next == PH_DRAIN);
        if (phase_next == PH_HEADER)
            st = skip_next ? ST_TRUNCATED : ST_SHORT;
        else if (phase_next == PH_DRAIN)
            st = err_next;
        else if (hdr)
            st = ST_TRUNCATED;
        else
            st = ST_SHORT;
        stat.kind       = KIND_STATUS;
        stat.status     = st;
        stat.end_of_run = 1'b1;
        if (hdr)
        begin
            stat.payload_type = header_next[23:16];
            stat.word_a       = {27'd0, header_next[28:24]};
        end
        if (packet.end_of_packet)
        begin
            phase_next = PH_IDLE;
            count_next = '0;
        end

        push = '0;
        if (fire)
        begin
            if (rec_valid && packet.end_of_packet)
            begin
                push.count  = 2'd2;
                push.first  = rec;
                push.second = stat;
            end
            else if (rec_valid)
            begin
                push.count            = 2'd1;
                push.first            = rec;
                push.first.end_of_run = 1'b1;
            end
            else if (packet.end_of_packet)
            begin
                push.count = 2'd1;
                push.first = stat;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/rpp_result_fifo.sv =====
// Four-entry result queue: up to two writes and one read per cycle.
// Depends on rpp_pkg, rpp_out_if.
`default_nettype none

module rpp_result_fifo
    import rpp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    rpp_out_if.source  report,
    output logic [2:0] level
);

    result_t    entry_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign report.valid  = (count_reg != 3'd0);
    assign report.result = entry_reg[rd_reg];
    assign pop           = report.valid & report.ready;
    assign level         = count_reg;

    always_comb
    begin
        wr_next    = wr_reg + {1'b0, push.count == 2'd1} + {push.count == 2'd2, 1'b0};
        rd_next    = rd_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push.count} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_reg + 2'd1] <= push.second;
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for rtcp_report_parser: directed and random RTCP packets,
// predicted result records checked beat by beat.
// Depends on rpp_pkg, rpp_in_if, rpp_out_if and the rtcp_report_parser RTL.
`timescale 1ns / 100ps

module tb;
    import rpp_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_BYTES = 700;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [7:0]  PT_BYE       = 8'd203;  // not in the package, accepted unparsed

    // ------------------------------------------------------------------
    // Parser model plus the queue of records it still owes us.
    // note_byte() mirrors the parser on each accepted input beat;
    // check_record() pops the oldest expectation for each output beat.
    // ------------------------------------------------------------------
    class report_tracker;
        result_t     pending_records[$];
        int unsigned errors;
        int unsigned kind_seen[3];

        phase_t      phase;
        logic [4:0]  nbytes;
        logic        skip;
        logic [31:0] header;
        logic [4:0]  blocks_left;
        logic [31:0] shift;
        logic [31:0] ssrc;
        logic [63:0] ntp;
        logic [31:0] words[4];
        logic [31:0] loss;
        logic [1:0]  err;

        function new();
            phase       = PH_IDLE;
            nbytes      = '0;
            skip        = 1'b0;
            header      = '0;
            blocks_left = '0;
            shift       = '0;
            ssrc        = '0;
            ntp         = '0;
            foreach (words[i]) words[i] = '0;
            loss        = '0;
            err         = ST_OK;
            errors      = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        // Header complete: pick the body phase from rc and type.
        function void start_body();
            logic [4:0] rc;
            logic [7:0] pt;
            rc          = header[28:24];
            pt          = header[23:16];
            err         = ST_OK;
            blocks_left = rc;
            nbytes      = '0;
            if (rc == 0)
                phase = PH_DRAIN;
            else if (pt == PT_SR)
                phase = PH_SENDER;
            else if (pt == PT_RR)
                phase = PH_RRSSRC;
            else if (pt >= PT_SDES && pt <= PT_APP)
                phase = PH_DRAIN;
            else
            begin
                phase = PH_DRAIN;
                err   = ST_UNKNOWN;
            end
        endfunction

        // A 32-bit word just completed; file it by its slot in the 24-byte record.
        function void store_word();
            logic [4:0] slot;
            slot = (nbytes >> 2) - 5'd1;
            if (slot == 0)
                ssrc = shift;
            else if (slot == 1)
            begin
                if (phase == PH_SENDER)
                    ntp = {shift, 32'h0};
                else
                    loss = shift;
            end
            else if (slot <= 5)
            begin
                words[slot - 2] = shift;
                if (phase == PH_SENDER && slot == 2)
                    ntp[31:0] = shift;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            result_t rec[2];
            int      n;
            logic    has_hdr;
            n      = 0;
            rec[0] = '0;
            rec[1] = '0;
            case (phase)
                PH_PREFIX:
                begin
                    nbytes++;
                    if (nbytes >= PREFIX_LEN)
                    begin
                        phase  = PH_HEADER;
                        nbytes = '0;
                        header = '0;
                    end
                end
                PH_HEADER:
                begin
                    header = {header[23:0], b};
                    nbytes++;
                    if (nbytes >= HEADER_LEN)
                        start_body();
                end
                PH_SENDER, PH_RRSSRC, PH_BLOCK:
                begin
                    shift = {shift[23:0], b};
                    nbytes++;
                    if (nbytes[1:0] == 2'b00)
                        store_word();
                    if (phase == PH_RRSSRC && nbytes >= SSRC_LEN)
                    begin
                        phase  = PH_BLOCK;
                        nbytes = '0;
                    end
                    else if (phase != PH_RRSSRC && nbytes >= RECORD_LEN)
                    begin
                        rec[n].payload_type = header[23:16];
                        rec[n].ssrc         = ssrc;
                        if (phase == PH_SENDER)
                        begin
                            rec[n].kind          = KIND_SENDER;
                            rec[n].ntp_timestamp = ntp;
                            rec[n].word_a        = words[1];
                            rec[n].word_b        = words[2];
                            rec[n].word_c        = words[3];
                            phase                = PH_BLOCK;
                        end
                        else
                        begin
                            rec[n].kind            = KIND_BLOCK;
                            rec[n].word_a          = words[0];
                            rec[n].word_b          = words[1];
                            rec[n].word_c          = words[2];
                            rec[n].word_d          = words[3];
                            rec[n].fraction_lost   = loss[31:24];
                            rec[n].cumulative_lost = loss[23:0];
                            blocks_left--;
                            if (blocks_left == 0)
                            begin
                                phase = PH_DRAIN;
                                err   = ST_OK;
                            end
                        end
                        n++;
                        nbytes = '0;
                    end
                end
                PH_DRAIN:
                    ;
                default:
                begin
                    // idle (or any stray phase): first byte of a packet
                    nbytes = 5'd1;
                    if (b == PREFIX_MARK)
                    begin
                        skip   = 1'b1;
                        phase  = PH_PREFIX;
                        header = '0;
                    end
                    else
                    begin
                        skip   = 1'b0;
                        header = {24'h0, b};
                        phase  = PH_HEADER;
                    end
                end
            endcase

            if (last)
            begin
                has_hdr     = (phase >= PH_SENDER && phase <= PH_DRAIN);
                rec[n].kind = KIND_STATUS;
                if (phase == PH_HEADER)
                    rec[n].status = skip ? ST_TRUNCATED : ST_SHORT;
                else if (phase == PH_DRAIN)
                    rec[n].status = err;
                else if (has_hdr)
                    rec[n].status = ST_TRUNCATED;
                else
                    rec[n].status = ST_SHORT;
                if (has_hdr)
                begin
                    rec[n].payload_type = header[23:16];
                    rec[n].word_a       = {27'h0, header[28:24]};
                end
                n++;
                phase  = PH_IDLE;
                nbytes = '0;
            end

            if (n > 0)
                rec[n - 1].end_of_run = 1'b1;
            for (int i = 0; i < n; i++)
                pending_records.push_back(rec[i]);
        endfunction

        function void diff(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_record(result_t got);
            result_t want;
            if (pending_records.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            if (want.kind <= KIND_STATUS)
                kind_seen[want.kind]++;
            diff("kind",            want.kind,            got.kind);
            diff("status",          want.status,          got.status);
            diff("payload_type",    want.payload_type,    got.payload_type);
            diff("ssrc",            want.ssrc,            got.ssrc);
            diff("ntp_timestamp",   want.ntp_timestamp,   got.ntp_timestamp);
            diff("word_a",          want.word_a,          got.word_a);
            diff("word_b",          want.word_b,          got.word_b);
            diff("word_c",          want.word_c,          got.word_c);
            diff("word_d",          want.word_d,          got.word_d);
            diff("fraction_lost",   want.fraction_lost,   got.fraction_lost);
            diff("cumulative_lost", want.cumulative_lost, got.cumulative_lost);
            diff("end_of_run",      want.end_of_run,      got.end_of_run);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #(CLK_PERIOD / 2) clk = ~clk;

    rpp_in_if  packet_ch();
    rpp_out_if report_ch();

    rtcp_report_parser i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (packet_ch),
        .report (report_ch)
    );

    report_tracker board;
    logic [7:0]    pkt_q[$];        // packet under construction
    int            burst_left;
    int            packets_sent;
    int            bytes_sent;
    int            random_bytes;

    // ------------------------------------------------------------------
    // Receiver: ready follows a rotating 16-bit mask. Each time mask_age wraps a new
    // mask is drawn; a third of the time it is all ones (no stalls at all).
    // ------------------------------------------------------------------
    logic [15:0] stall_mask;
    int          mask_age;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            report_ch.ready <= 1'b0;
            stall_mask      <= '1;
            mask_age        <= 0;
        end
        else
        begin
            report_ch.ready <= stall_mask[0];
            if (mask_age == 63)
            begin
                mask_age   <= 0;
                stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            end
            else
            begin
                mask_age   <= mask_age + 1;
                stall_mask <= {stall_mask[0], stall_mask[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitors: both sample pre-edge values at the accepting edge.
    // A byte's records enter the DUT queue at its accept edge, so they can
    // only leave on a later edge; checking before noting is safe.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (report_ch.valid && report_ch.ready)
                board.check_record(report_ch.result);
            if (packet_ch.valid && packet_ch.ready)
                board.note_byte(packet_ch.byte_in, packet_ch.end_of_packet);
        end
    end

    // ------------------------------------------------------------------
    // Packet building helpers
    // ------------------------------------------------------------------
    function automatic void put_random(int n);
        for (int i = 0; i < n; i++)
            pkt_q.push_back(8'($urandom));
    endfunction

    function automatic void put_fill(int n, logic [7:0] value);
        for (int i = 0; i < n; i++)
            pkt_q.push_back(value);
    endfunction

    // '$' marker plus three channel/length bytes
    function automatic void put_prefix();
        pkt_q.push_back(PREFIX_MARK);
        put_random(int'(PREFIX_LEN) - 1);
    endfunction

    // version/padding and length are random; the parser ignores them
    function automatic void put_header(logic [4:0] rc, logic [7:0] pt);
        logic [2:0] vp;
        vp = 3'($urandom_range(0, 7));
        pkt_q.push_back({vp, rc});
        pkt_q.push_back(pt);
        put_random(2);
    endfunction

    // body bytes that an SR or RR needs before its status: SR carries a 24-byte
    // sender info, RR only the 4-byte sender SSRC
    function automatic int report_body_len(logic [7:0] pt, int rc);
        return ((pt == PT_SR) ? int'(RECORD_LEN) : int'(SSRC_LEN)) + int'(RECORD_LEN) * rc;
    endfunction

    // One beat per byte. The sender runs in bursts; between bursts it drops
    // valid for a random gap, or not at all. valid is left high across
    // back-to-back beats so it gets a single update per edge.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                packet_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        packet_ch.valid         <= 1'b1;
        packet_ch.byte_in       <= b;
        packet_ch.end_of_packet <= last;
        @(posedge clk);
        while (!packet_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
        bytes_sent += pkt_q.size();
        packets_sent++;
        pkt_q.delete();
    endtask

    // Random packet mix: mostly complete SR/RR with random content, some cut
    // short, some other or unknown types, some plain noise. A quarter carry
    // the interleave prefix.
    task automatic build_random_packet();
        int         sel;
        int         rc;
        int         body;
        logic [7:0] pt;
        if ($urandom_range(0, 3) == 0)
            put_prefix();
        sel = $urandom_range(0, 19);
        if (sel < 14)
        begin
            pt = (sel % 2 == 0) ? PT_SR : PT_RR;
            rc = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
            put_header(5'(rc), pt);
            body = report_body_len(pt, rc);
            if (sel >= 11)
                body = $urandom_range(0, body - 1);     // ends mid-record
            put_random(body);
            if (sel < 11 && $urandom_range(0, 2) == 0)
                put_random($urandom_range(1, 4));       // trailing junk
        end
        else if (sel < 17)
        begin
            case ($urandom_range(0, 3))
                0:       pt = PT_SDES;
                1:       pt = PT_BYE;
                2:       pt = PT_APP;
                default: pt = 8'($urandom);
            endcase
            rc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31);
            put_header(5'(rc), pt);
            put_random($urandom_range(0, 12));
        end
        else
            put_random($urandom_range(1, 9));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        board                   = new();
        rst_n                   = 1'b0;
        packet_ch.valid         = 1'b0;
        packet_ch.byte_in       = 8'h00;
        packet_ch.end_of_packet = 1'b0;
        report_ch.ready         = 1'b0;
        burst_left              = 0;
        packets_sent            = 0;
        bytes_sent              = 0;
        random_bytes            = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // short packets: one byte, lone '$', three bytes
        put_fill(1, 8'h80);
        send_packet();
        pkt_q.push_back(PREFIX_MARK);
        send_packet();
        put_fill(1, 8'h81);
        put_random(2);
        send_packet();
        // prefix eats the header: 4 and 7 bytes including '$'
        put_prefix();
        send_packet();
        put_prefix();
        put_random(3);
        send_packet();
        // complete SR, all-ones and all-zeros bodies (record + status on last byte)
        put_header(5'd1, PT_SR);
        put_fill(report_body_len(PT_SR, 1), 8'hFF);
        send_packet();
        put_prefix();
        put_header(5'd1, PT_SR);
        put_fill(report_body_len(PT_SR, 1), 8'h00);
        send_packet();
        // complete RR with two blocks and trailing bytes
        put_header(5'd2, PT_RR);
        put_random(report_body_len(PT_RR, 2) + 3);
        send_packet();
        // known types left unparsed, max report count
        put_header(5'd31, PT_SDES);
        put_random(8);
        send_packet();
        put_header(5'd31, PT_BYE);
        put_random(4);
        send_packet();
        put_header(5'd17, PT_APP);
        send_packet();
        // unknown types
        put_header(5'd1, 8'd0);
        send_packet();
        put_fill(4, 8'hFF);
        put_random(6);
        send_packet();
        put_header(5'd5, 8'd199);
        put_random(2);
        send_packet();
        // zero count: ok for a report type and for an unknown type
        put_header(5'd0, PT_SR);
        put_random(8);
        send_packet();
        put_header(5'd0, 8'd7);
        send_packet();
        // early end: header only, mid second block, inside the RR sender SSRC
        put_header(5'd1, PT_SR);
        send_packet();
        put_header(5'd2, PT_SR);
        put_random(int'(RECORD_LEN) * 2 + 10);
        send_packet();
        put_header(5'd1, PT_RR);
        put_random(2);
        send_packet();
        // one byte short of the last block
        put_prefix();
        put_header(5'd1, PT_RR);
        put_random(report_body_len(PT_RR, 1) - 1);
        send_packet();

        // --- random part ---
        while (random_bytes < RANDOM_BYTES)
        begin
            build_random_packet();
            random_bytes += pkt_q.size();
            send_packet();
        end
        packet_ch.valid <= 1'b0;

        // wait for every owed record, then keep watching for strays
        while (board.pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d packets, %0d bytes (with '$' prefixes, cut and unknown packets)",
                 packets_sent, bytes_sent);
        $display("checked %0d sender info, %0d report block and %0d status records",
                 board.kind_seen[KIND_SENDER], board.kind_seen[KIND_BLOCK],
                 board.kind_seen[KIND_STATUS]);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop, far beyond any correct run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d records outstanding", board.pending_records.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
